[rtl/core/toda_pkg.sv]
// ----------------------------------------------------------------------------
// toda_pkg: shared types and constants of the time-of-day ALU
// Millisecond constants, opcodes, beat payloads and the cell word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package toda_pkg;

  // width of a millisecond total (face-value fields stay below 2^27)
  localparam int unsigned TW = 27;

  localparam logic [TW-1:0] MS_PER_SEC  = 27'd1000;
  localparam logic [TW-1:0] MS_PER_MIN  = 27'd60000;
  localparam logic [TW-1:0] MS_PER_HR   = 27'd3600000;
  localparam logic [TW-1:0] MS_PER_DAY  = 27'd86400000;
  localparam logic [TW:0]   MS_PER_2DAY = 28'd172800000;

  // cells per division phase
  localparam int unsigned DIV_CELLS = TW;
  localparam int unsigned HR_CELLS  = 5;
  localparam int unsigned MIN_CELLS = 6;
  localparam int unsigned SEC_CELLS = 6;

  // opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_DIVT = 3'd2;
  localparam logic [2:0] OP_DIVI = 3'd3;
  localparam logic [2:0] OP_MUL  = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  a_hours;
    logic [5:0]  a_minutes;
    logic [5:0]  a_seconds;
    logic [9:0]  a_millis;
    logic [4:0]  b_hours;
    logic [5:0]  b_minutes;
    logic [5:0]  b_seconds;
    logic [9:0]  b_millis;
    logic [15:0] factor;
  } in_t;

  typedef struct packed {
    logic [4:0] r_hours;
    logic [5:0] r_minutes;
    logic [5:0] r_seconds;
    logic [9:0] r_millis;
    logic       valid_res;
  } out_t;

  // data riding along the cell row
  typedef struct packed {
    logic [2:0]    op;
    logic [TW-1:0] r;
    logic          v;
    logic [4:0]    hrs;
    logic [5:0]    mins;
  } side_t;

  // one stage of the cell row: partial remainder, dividend/quotient, divisor
  typedef struct packed {
    logic          valid;
    logic [TW-1:0] p;
    logic [TW-1:0] nq;
    logic [TW-1:0] d;
    side_t         side;
  } cell_t;

  // h:m:s:ms to a millisecond total
  function automatic logic [TW-1:0] to_ms(logic [4:0] h, logic [5:0] m,
                                          logic [5:0] s, logic [9:0] ms);
    logic [TW-1:0] acc;
    acc = TW'(h) * MS_PER_HR + TW'(m) * MS_PER_MIN + TW'(s) * MS_PER_SEC + TW'(ms);
    return acc;
  endfunction

endpackage

`default_nettype wire

[rtl/core/toda_in_if.sv]
// ----------------------------------------------------------------------------
// toda_in_if: operand channel
// Valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface toda_in_if;
  import toda_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/toda_out_if.sv]
// ----------------------------------------------------------------------------
// toda_out_if: result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface toda_out_if;
  import toda_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/time_of_day_alu_top.sv]
// ----------------------------------------------------------------------------
// time_of_day_alu_top: time-of-day ALU on h:m:s:ms
// Add, subtract, divide by time, divide by integer and multiply on
// millisecond totals, result split back into h:m:s:ms.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation beat (opcode, times A and B, factor);
//   out_o returns one result beat per operation, in order.
//   A beat moves when valid and ready are both high.
//   The path from the accepting edge to out_o.valid runs through three
//   front stages, a row of 27 restoring-division cells (one quotient bit
//   each), one fixup stage, 17 split cells (hours, minutes, seconds)
//   and the output register.
//   Throughput is one beat per cycle while the skid register is empty;
//   the cell row advances only then and every item takes the full row, whatever its opcode.
//   A skid register behind the output register catches one beat when the
//   receiver stalls; while it is full the whole row holds and in_i.ready
//   is low. ready comes from a register only.
//   Reset clears all valid bits; the block accepts beats in the first
//   cycle after reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module time_of_day_alu_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  toda_in_if.sink    in_i,
  toda_out_if.source out_o
);
  import toda_pkg::*;

  logic  en;
  logic  incoming;
  logic  take;

  cell_t div_c [DIV_CELLS+1];
  cell_t hr_c  [HR_CELLS+1];
  cell_t min_c [MIN_CELLS+1];
  cell_t sec_c [SEC_CELLS+1];

  cell_t fix_d, fix_q;
  logic  fix_v_q;
  out_t  res;
  out_t  out_q, skid_q;
  logic  out_v_q, skid_v_q;

  // row advances while the skid register is empty
  assign en         = !skid_v_q;
  assign in_i.ready = en;

  // front stages
  toda_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .cell_o  (div_c[0])
  );

  // quotient of the divide operations
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    toda_cell u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
      .cell_i (div_c[i]), .cell_o (div_c[i+1])
    );
  end

  // fixup: zero divisor and out-of-day quotients
  always_comb begin
    fix_d = div_c[DIV_CELLS];
    if ((fix_d.side.op == OP_DIVT) || (fix_d.side.op == OP_DIVI)) begin
      if (fix_d.d == '0) begin
        fix_d.side.r = '0;
        fix_d.side.v = (fix_d.side.op == OP_DIVT);
      end else if (fix_d.nq >= MS_PER_DAY) begin
        fix_d.side.r = '0;
        fix_d.side.v = 1'b0;
      end else begin
        fix_d.side.r = fix_d.nq;
        fix_d.side.v = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_v_q <= 1'b0;
    end else if (en) begin
      fix_v_q <= fix_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fix_q <= fix_d;
    end
  end

  // hour phase load: dividend pre-shifted by the quotient width
  always_comb begin
    hr_c[0]       = fix_q;
    hr_c[0].valid = fix_v_q;
    hr_c[0].p     = TW'(fix_q.side.r[TW-1:HR_CELLS]);
    hr_c[0].nq    = {fix_q.side.r[HR_CELLS-1:0], (TW-HR_CELLS)'(0)};
    hr_c[0].d     = MS_PER_HR;
  end

  for (genvar i = 0; i < HR_CELLS; i++) begin : g_hr
    toda_cell u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
      .cell_i (hr_c[i]), .cell_o (hr_c[i+1])
    );
  end

  // minute phase load
  always_comb begin
    min_c[0]          = hr_c[HR_CELLS];
    min_c[0].side.hrs = hr_c[HR_CELLS].nq[HR_CELLS-1:0];
    min_c[0].p        = TW'(hr_c[HR_CELLS].p[TW-1:MIN_CELLS]);
    min_c[0].nq       = {hr_c[HR_CELLS].p[MIN_CELLS-1:0], (TW-MIN_CELLS)'(0)};
    min_c[0].d        = MS_PER_MIN;
  end

  for (genvar i = 0; i < MIN_CELLS; i++) begin : g_min
    toda_cell u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
      .cell_i (min_c[i]), .cell_o (min_c[i+1])
    );
  end

  // second phase load
  always_comb begin
    sec_c[0]           = min_c[MIN_CELLS];
    sec_c[0].side.mins = min_c[MIN_CELLS].nq[MIN_CELLS-1:0];
    sec_c[0].p         = TW'(min_c[MIN_CELLS].p[TW-1:SEC_CELLS]);
    sec_c[0].nq        = {min_c[MIN_CELLS].p[SEC_CELLS-1:0], (TW-SEC_CELLS)'(0)};
    sec_c[0].d         = MS_PER_SEC;
  end

  for (genvar i = 0; i < SEC_CELLS; i++) begin : g_sec
    toda_cell u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
      .cell_i (sec_c[i]), .cell_o (sec_c[i+1])
    );
  end

  // result beat
  always_comb begin
    res.r_hours   = sec_c[SEC_CELLS].side.hrs;
    res.r_minutes = sec_c[SEC_CELLS].side.mins;
    res.r_seconds = sec_c[SEC_CELLS].nq[SEC_CELLS-1:0];
    res.r_millis  = sec_c[SEC_CELLS].p[9:0];
    res.valid_res = sec_c[SEC_CELLS].side.v;
  end

  assign incoming = en && sec_c[SEC_CELLS].valid;
  assign take     = out_v_q && out_o.ready;

  // output register and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      out_v_q  <= skid_v_q || incoming;
      skid_v_q <= 1'b0;
    end else if (incoming) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (incoming) begin
      skid_q <= res;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

`ifndef NO_ASSERTIONS
  // skid only fills behind a held output
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid full with output empty");

  // taken output drains the skid
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && take |=> !skid_v_q && out_v_q)
    else $error("skid not drained");

  // result fields always in range
  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.r_hours < 5'd24) && (out_q.r_minutes < 6'd60) &&
                (out_q.r_seconds < 6'd60) && (out_q.r_millis < 10'd1000))
    else $error("result field out of range");
`endif

endmodule

`default_nettype wire

[rtl/core/toda_cell.sv]
// ----------------------------------------------------------------------------
// toda_cell: one restoring-division cell
// Shifts one dividend bit into the remainder, compares, subtracts and
// shifts one quotient bit in; hands the word to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module toda_cell (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             en_i,
  input  toda_pkg::cell_t cell_i,
  output toda_pkg::cell_t cell_o
);
  import toda_pkg::*;

  logic [TW:0]   trial;
  logic [TW:0]   diff;
  logic          ge;
  cell_t         cell_d;
  cell_t         cell_q;

  // compare and subtract step
  always_comb begin
    trial        = {cell_i.p, cell_i.nq[TW-1]};
    diff         = trial - {1'b0, cell_i.d};
    ge           = (trial >= {1'b0, cell_i.d});
    cell_d       = cell_i;
    cell_d.p     = ge ? diff[TW-1:0] : trial[TW-1:0];
    cell_d.nq    = {cell_i.nq[TW-2:0], ge};
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

`ifndef NO_ASSERTIONS
  // remainder stays below a nonzero divisor
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_q.valid && (cell_q.d != '0) |-> cell_q.p < cell_q.d)
    else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

[rtl/core/toda_front.sv]
// ----------------------------------------------------------------------------
// toda_front: operand conversion and non-division operations
// Three stages: millisecond totals, add/subtract/multiply, result select
// and divider load word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module toda_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             en_i,
  input  wire             valid_i,
  input  toda_pkg::in_t   data_i,
  output toda_pkg::cell_t cell_o
);
  import toda_pkg::*;

  // stage 0 registers
  logic          v0_q;
  logic [2:0]    op0_q;
  logic [TW-1:0] ta0_q, tb0_q;
  logic [15:0]   f0_q;

  // stage 1 registers
  logic          v1_q;
  logic [2:0]    op1_q;
  logic [TW-1:0] ta1_q, tb1_q, sum1_q, am1_q, bm1_q;
  logic [15:0]   f1_q;
  logic [42:0]   prod1_q;

  logic [TW:0]   sum;
  logic [TW-1:0] sum_mod, am, bm;
  logic [TW:0]   wrap;
  logic [TW-1:0] dif;
  cell_t         cell_d, cell_q;

  // valid bits and the divider load word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      cell_q <= '0;
    end else if (en_i) begin
      v0_q   <= valid_i;
      v1_q   <= v0_q;
      cell_q <= cell_d;
    end
  end

  // stage 0: millisecond totals
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op0_q <= data_i.opcode;
      ta0_q <= to_ms(data_i.a_hours, data_i.a_minutes, data_i.a_seconds, data_i.a_millis);
      tb0_q <= to_ms(data_i.b_hours, data_i.b_minutes, data_i.b_seconds, data_i.b_millis);
      f0_q  <= data_i.factor;
    end
  end

  // stage 1: sum mod day, operands mod day, product
  always_comb begin
    sum = {1'b0, ta0_q} + {1'b0, tb0_q};
    if (sum >= MS_PER_2DAY) begin
      sum_mod = TW'(sum - MS_PER_2DAY);
    end else if (sum >= {1'b0, MS_PER_DAY}) begin
      sum_mod = TW'(sum - {1'b0, MS_PER_DAY});
    end else begin
      sum_mod = sum[TW-1:0];
    end
    am = (ta0_q >= MS_PER_DAY) ? ta0_q - MS_PER_DAY : ta0_q;
    bm = (tb0_q >= MS_PER_DAY) ? tb0_q - MS_PER_DAY : tb0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= op0_q;
      ta1_q   <= ta0_q;
      tb1_q   <= tb0_q;
      f1_q    <= f0_q;
      sum1_q  <= sum_mod;
      am1_q   <= am;
      bm1_q   <= bm;
      prod1_q <= 43'(ta0_q) * 43'(f0_q);
    end
  end

  // stage 2: difference, product range check, result select
  always_comb begin
    wrap = {1'b0, am1_q} + {1'b0, MS_PER_DAY} - {1'b0, bm1_q};
    dif  = (am1_q >= bm1_q) ? am1_q - bm1_q : wrap[TW-1:0];

    cell_d           = '0;
    cell_d.valid     = v1_q;
    cell_d.nq        = ta1_q;
    cell_d.d         = (op1_q == OP_DIVT) ? tb1_q : TW'(f1_q);
    cell_d.side.op   = op1_q;
    cell_d.side.v    = 1'b1;
    unique case (op1_q)
      OP_ADD:  cell_d.side.r = sum1_q;
      OP_SUB:  cell_d.side.r = dif;
      OP_MUL:  cell_d.side.r = (prod1_q >= 43'(MS_PER_DAY)) ? '0 : prod1_q[TW-1:0];
      OP_DIVT,
      OP_DIVI: cell_d.side.r = '0;
      default: begin
        cell_d.side.r = '0;
        cell_d.side.v = 1'b0;
      end
    endcase
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the time-of-day ALU
// Drives operation beats from a directed table, then random beats. Every
// accepted beat without a typed result is run through a millisecond-total
// predictor, and each result beat is compared field by field in order. Both
// channels stall at random, with a long receiver hold-off and one drain
// pause on the operand side.
`timescale 1ns / 1ps

module tb_top;
  import toda_pkg::*;

  localparam longint unsigned DAY_MS      = 64'd86400000;
  localparam int unsigned     CYCLE_LIMIT = 200000;
  localparam int unsigned     DRAIN_WAIT  = 60;
  localparam logic [2:0]      OP_NONE5    = 3'd5;
  localparam logic [2:0]      OP_NONE7    = 3'd7;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t res;
  } row_t;

  logic clk_i;
  logic rst_ni;

  toda_in_if  op_if ();
  toda_out_if res_if ();

  time_of_day_alu_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .out_o  (res_if)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  out_t        pending_q[$];
  row_t        op_table[$];
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          rx_hold_req;
  int unsigned mismatches;
  int unsigned cycles;
  bit          next_typed;
  out_t        next_res;

  // millisecond total at face value of the field bits
  function automatic longint unsigned total_ms(logic [4:0] h, logic [5:0] m,
                                               logic [5:0] s, logic [9:0] ms);
    return ((longint'(h) * 60 + m) * 60 + s) * 1000 + ms;
  endfunction

  function automatic out_t split_ms(longint unsigned t, logic v);
    out_t o;
    o.r_millis  = 10'(t % 1000);
    t           = t / 1000;
    o.r_seconds = 6'(t % 60);
    t           = t / 60;
    o.r_minutes = 6'(t % 60);
    o.r_hours   = 5'(t / 60);
    o.valid_res = v;
    return o;
  endfunction

  // expected result of one operation beat
  function automatic out_t predict_time(in_t x);
    longint unsigned ta;
    longint unsigned tb;
    longint unsigned r;
    logic            v;
    ta = total_ms(x.a_hours, x.a_minutes, x.a_seconds, x.a_millis);
    tb = total_ms(x.b_hours, x.b_minutes, x.b_seconds, x.b_millis);
    r  = 0;
    v  = 1'b1;
    case (x.opcode)
      OP_ADD: r = (ta + tb) % DAY_MS;
      OP_SUB: r = ((ta % DAY_MS) + DAY_MS - (tb % DAY_MS)) % DAY_MS;
      OP_DIVT: begin
        if (tb != 0) begin
          r = ta / tb;
          if (r >= DAY_MS) begin
            r = 0;
            v = 1'b0;
          end
        end
      end
      OP_DIVI: begin
        if (x.factor == 0) begin
          v = 1'b0;
        end else begin
          r = ta / x.factor;
          if (r >= DAY_MS) begin
            r = 0;
            v = 1'b0;
          end
        end
      end
      OP_MUL: begin
        r = ta * x.factor;
        if (r >= DAY_MS) r = 0;
      end
      default: v = 1'b0;
    endcase
    return split_ms(r, v);
  endfunction

  function automatic in_t mk_beat(logic [2:0] op, logic [4:0] ah, logic [5:0] am,
                                  logic [5:0] as, logic [9:0] ams, logic [4:0] bh,
                                  logic [5:0] bm, logic [5:0] bs, logic [9:0] bms,
                                  logic [15:0] f);
    in_t x;
    x = '{op, ah, am, as, ams, bh, bm, bs, bms, f};
    return x;
  endfunction

  function automatic out_t mk_res(logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                  logic [9:0] ms, logic v);
    out_t o;
    o = '{h, m, s, ms, v};
    return o;
  endfunction

  task automatic add_row(in_t x, bit typed, out_t e);
    row_t rw;
    rw.beat  = x;
    rw.typed = typed;
    rw.res   = e;
    op_table.push_back(rw);
  endtask

  // random operation beat, mostly in range, sometimes full field width
  function automatic in_t rand_beat();
    in_t x;
    x.opcode = ($urandom_range(99) < 90) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
    if ($urandom_range(99) < 85) begin
      x.a_hours   = 5'($urandom_range(23));
      x.a_minutes = 6'($urandom_range(59));
      x.a_seconds = 6'($urandom_range(59));
      x.a_millis  = 10'($urandom_range(999));
    end else begin
      x.a_hours   = 5'($urandom);
      x.a_minutes = 6'($urandom);
      x.a_seconds = 6'($urandom);
      x.a_millis  = 10'($urandom);
    end
    case ($urandom_range(3))
      0: begin
        x.b_hours   = '0;
        x.b_minutes = '0;
        x.b_seconds = 6'($urandom_range(1));
        x.b_millis  = 10'($urandom_range(3));
      end
      1: begin
        x.b_hours   = 5'($urandom);
        x.b_minutes = 6'($urandom);
        x.b_seconds = 6'($urandom);
        x.b_millis  = 10'($urandom);
      end
      default: begin
        x.b_hours   = 5'($urandom_range(23));
        x.b_minutes = 6'($urandom_range(59));
        x.b_seconds = 6'($urandom_range(59));
        x.b_millis  = 10'($urandom_range(999));
      end
    endcase
    case ($urandom_range(3))
      0: x.factor = 16'($urandom_range(3));
      1: x.factor = 16'($urandom_range(255));
      2: x.factor = 16'(1 << $urandom_range(15));
      default: x.factor = 16'($urandom);
    endcase
    return x;
  endfunction

  // drive one beat at the falling edge and hold it until accepted
  task automatic send_beat(in_t x, bit typed, out_t e);
    while ($urandom_range(99) < tx_idle_pct) begin
      op_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    next_typed = typed;
    next_res   = e;
    op_if.valid <= 1'b1;
    op_if.data  <= x;
    @(posedge clk_i);
    while (!op_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver ready, with one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result check and expectation capture at the rising edge
  always @(posedge clk_i) begin
    out_t e;
    out_t a;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        a = res_if.data;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", a);
        end else begin
          e = pending_q.pop_front();
          if (a.r_hours !== e.r_hours || a.r_minutes !== e.r_minutes ||
              a.r_seconds !== e.r_seconds || a.r_millis !== e.r_millis ||
              a.valid_res !== e.valid_res) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch exp %p got %p", e, a);
          end
        end
      end
      if (op_if.valid && op_if.ready)
        pending_q.push_back(next_typed ? next_res : predict_time(op_if.data));
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL time_of_day_alu_top");
      $finish;
    end
  end

  // stimulus
  initial begin
    out_t z;
    z            = '0;
    mismatches   = 0;
    cycles       = 0;
    rx_hold_req  = 1'b0;
    tx_idle_pct  = 26;
    rx_idle_pct  = 60;
    next_typed   = 1'b0;
    next_res     = '0;
    rst_ni       = 1'b0;
    op_if.valid  = 1'b0;
    op_if.data   = '0;

    // directed rows, result typed where it is obvious
    add_row(mk_beat(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 1));
    add_row(mk_beat(OP_ADD, 23, 59, 59, 999, 0, 0, 0, 1, 0), 1, mk_res(0, 0, 0, 0, 1));
    add_row(mk_beat(OP_ADD, 23, 59, 59, 999, 23, 59, 59, 999, 16'hffff), 1,
            mk_res(23, 59, 59, 998, 1));
    add_row(mk_beat(OP_SUB, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1, mk_res(23, 59, 59, 999, 1));
    add_row(mk_beat(OP_SUB, 12, 30, 15, 500, 1, 1, 1, 1, 0), 1, mk_res(11, 29, 14, 499, 1));
    add_row(mk_beat(OP_SUB, 31, 63, 63, 1023, 31, 63, 63, 1023, 0), 1, mk_res(0, 0, 0, 0, 1));
    add_row(mk_beat(OP_DIVT, 23, 59, 59, 999, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 1));
    add_row(mk_beat(OP_DIVT, 23, 59, 59, 999, 0, 0, 0, 1, 0), 1, mk_res(23, 59, 59, 999, 1));
    add_row(mk_beat(OP_DIVT, 31, 63, 63, 1023, 0, 0, 0, 1, 0), 1, mk_res(0, 0, 0, 0, 0));
    add_row(mk_beat(OP_DIVT, 10, 0, 0, 0, 0, 0, 1, 0, 0), 0, z);
    add_row(mk_beat(OP_DIVI, 23, 59, 59, 999, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 0));
    add_row(mk_beat(OP_DIVI, 23, 59, 59, 999, 0, 0, 0, 0, 1), 1, mk_res(23, 59, 59, 999, 1));
    add_row(mk_beat(OP_DIVI, 31, 63, 63, 1023, 0, 0, 0, 0, 1), 1, mk_res(0, 0, 0, 0, 0));
    add_row(mk_beat(OP_DIVI, 23, 59, 59, 999, 0, 0, 0, 0, 16'hffff), 0, z);
    add_row(mk_beat(OP_MUL, 23, 59, 59, 999, 0, 0, 0, 0, 2), 1, mk_res(0, 0, 0, 0, 1));
    add_row(mk_beat(OP_MUL, 23, 59, 59, 999, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 1));
    add_row(mk_beat(OP_MUL, 0, 0, 0, 1, 0, 0, 0, 0, 16'hffff), 1, mk_res(0, 1, 5, 535, 1));
    add_row(mk_beat(OP_MUL, 31, 63, 63, 1023, 0, 0, 0, 0, 16'hffff), 1, mk_res(0, 0, 0, 0, 1));
    add_row(mk_beat(OP_MUL, 1, 2, 3, 4, 0, 0, 0, 0, 7), 0, z);
    add_row(mk_beat(OP_NONE5, 23, 59, 59, 999, 23, 59, 59, 999, 16'hffff), 1,
            mk_res(0, 0, 0, 0, 0));
    add_row(mk_beat(OP_NONE7, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 0));

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (op_table[i]) send_beat(op_table[i].beat, op_table[i].typed, op_table[i].res);

    // sender keeps offering while the receiver holds off
    rx_hold_req = 1'b1;
    for (int i = 0; i < 300; i++) begin
      if (i == 150) begin
        // drain pause: let every pending result come out
        op_if.valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(negedge clk_i);
      end
      send_beat(rand_beat(), 0, z);
    end

    tx_idle_pct = 60;
    rx_idle_pct = 26;
    for (int i = 0; i < 300; i++) send_beat(rand_beat(), 0, z);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 250; i++) send_beat(rand_beat(), 0, z);
    op_if.valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("PASS time_of_day_alu_top");
    end else begin
      $display("FAIL time_of_day_alu_top");
    end
    $finish;
  end

endmodule
